>>> hdl/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W = 6;
    localparam int CHAR_W = 7;
    localparam int PC_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // program steps
    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [PC_W-1:0] STEP_NEGATE = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV_INIT = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV_BIT = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIGIT = 3'd4;
    localparam logic [PC_W-1:0] STEP_SIGN = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_NEGATE,
        OP_DIV_INIT,
        OP_DIV_BIT,
        OP_EMIT_DIGIT,
        OP_EMIT_SIGN
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_NO_START,
        COND_CNT_MORE,
        COND_QUOT_NZ
    } cond_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            busy;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic cnt_last;
        logic quot_nz;
    } status_t;

    function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_IDLE:     w = '{OP_LOAD, COND_NO_START, STEP_IDLE, 1'b0};
            STEP_NEGATE:   w = '{OP_NEGATE, COND_NEVER, STEP_IDLE, 1'b1};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER, STEP_IDLE, 1'b1};
            STEP_DIV_BIT:  w = '{OP_DIV_BIT, COND_CNT_MORE, STEP_DIV_BIT, 1'b1};
            STEP_DIGIT:    w = '{OP_EMIT_DIGIT, COND_QUOT_NZ, STEP_DIV_INIT, 1'b1};
            STEP_SIGN:     w = '{OP_EMIT_SIGN, COND_ALWAYS, STEP_IDLE, 1'b1};
            default:       w = '{OP_NONE, COND_ALWAYS, STEP_IDLE, 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_A + CHAR_W'(d - 6'd10);
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/i2a_seq.sv
`default_nettype none

module i2a_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire i2a_pkg::status_t status,
    output i2a_pkg::ctrl_t       ctrl
);

    logic [i2a_pkg::PC_W-1:0] pc_reg;
    logic [i2a_pkg::PC_W-1:0] pc_next;
    logic                     take_jump;

    assign ctrl = i2a_pkg::prog_word(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            i2a_pkg::COND_ALWAYS:   take_jump = 1'b1;
            i2a_pkg::COND_NEVER:    take_jump = 1'b0;
            i2a_pkg::COND_NO_START: take_jump = !status.start;
            i2a_pkg::COND_CNT_MORE: take_jump = !status.cnt_last;
            i2a_pkg::COND_QUOT_NZ:  take_jump = status.quot_nz;
            default:                take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take_jump)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= i2a_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

>>> hdl/integer_to_ascii_any_base.sv
`default_nettype none

// integer to ascii converter, any base 2..36
// an item is taken at a clock edge with start high and busy low; value holds the
// integer, signed_mode says whether it is two's complement
// characters leave least significant digit first, one per out_valid pulse; in
// signed mode a negative value is followed by '-', and last marks the final one
// out_valid is high for exactly one cycle per character and cannot be held off
// the base comes from the cfg channel (cfg_ready is always high); writes below 2
// store 2, above 36 store 36; write it only while busy is low
// each digit comes out of a restoring divider that retires one quotient bit per
// cycle; a digit takes an init step, the bit steps and an emit step
// busy stays high from the negate step through the sign step, so a new item is
// taken only once the last one is through
// each character appears in the cycle after the program step that produces it
// reset clears the sequencer, the output strobe and sets the base to 10

module integer_to_ascii_any_base #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [VALUE_WIDTH-1:0]       value,
    input  wire logic                         signed_mode,
    output logic                              out_valid,
    output logic [i2a_pkg::CHAR_W-1:0]        out_char,
    output logic                              last,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [i2a_pkg::RADIX_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    i2a_pkg::ctrl_t   ctrl;
    i2a_pkg::status_t status;

    logic [i2a_pkg::RADIX_W-1:0] radix_reg;
    logic [VALUE_WIDTH-1:0]      num_reg;
    logic [VALUE_WIDTH-1:0]      num_next;
    logic [i2a_pkg::RADIX_W-1:0] rem_reg;
    logic [i2a_pkg::RADIX_W-1:0] rem_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]  out_char_reg;
    logic [i2a_pkg::CHAR_W-1:0]  out_char_next;
    logic                        last_reg;
    logic                        last_next;
    logic [i2a_pkg::RADIX_W:0]   trial;
    logic                        trial_ge;

    i2a_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign status.start    = start;
    assign status.cnt_last = (cnt_reg == CNT_W'(1));
    assign status.quot_nz  = (num_reg != '0);

    assign busy      = ctrl.busy;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= i2a_pkg::RADIX_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data < i2a_pkg::RADIX_MIN)
                radix_reg <= i2a_pkg::RADIX_MIN;
            else if (cfg_data > i2a_pkg::RADIX_MAX)
                radix_reg <= i2a_pkg::RADIX_MAX;
            else
                radix_reg <= cfg_data;
        end
    end

    // one restoring divide step: remainder picks up the next dividend bit
    assign trial    = {rem_reg, num_reg[VALUE_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, radix_reg});

    always_comb
    begin
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = 1'b0;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        case (ctrl.op)
            i2a_pkg::OP_LOAD:
            begin
                if (start)
                begin
                    num_next = value;
                    neg_next = signed_mode & value[VALUE_WIDTH-1];
                end
            end
            i2a_pkg::OP_NEGATE:
            begin
                // most negative value wraps to its unsigned magnitude
                if (neg_reg)
                    num_next = ~num_reg + 1'b1;
            end
            i2a_pkg::OP_DIV_INIT:
            begin
                rem_next = '0;
                cnt_next = CNT_W'(VALUE_WIDTH);
            end
            i2a_pkg::OP_DIV_BIT:
            begin
                if (trial_ge)
                    rem_next = i2a_pkg::RADIX_W'(trial - {1'b0, radix_reg});
                else
                    rem_next = trial[i2a_pkg::RADIX_W-1:0];
                num_next = {num_reg[VALUE_WIDTH-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            i2a_pkg::OP_EMIT_DIGIT:
            begin
                out_valid_next = 1'b1;
                out_char_next  = i2a_pkg::digit_char(rem_reg);
                last_next      = (num_reg == '0) && !neg_reg;
            end
            i2a_pkg::OP_EMIT_SIGN:
            begin
                out_valid_next = neg_reg;
                out_char_next  = i2a_pkg::CHAR_MINUS;
                last_next      = 1'b1;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire
